// File: rtl/lcd_init_pkg.sv
// Package: types and constants for the display init table player.
`default_nettype none
package lcd_init_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned CmdCntW   = 8;
  localparam int unsigned ArgCntW   = 7;
  localparam int unsigned KindW     = 2;
  localparam int unsigned OutDataW  = 32;
  localparam int unsigned QueueAw   = 2;
  localparam int unsigned QueueCntW = QueueAw + 1;

  localparam logic [ByteW-1:0]  LongCode     = 8'd255;
  localparam logic [DelayW-1:0] LongDelayRst = 16'd500;

  typedef enum logic [KindW-1:0] {
    KIND_CMD     = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_DELAY   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_OPCODE = 3'd1,
    PH_ARGC   = 3'd2,
    PH_ARG    = 3'd3,
    PH_DELAY  = 3'd4,
    PH_IDLE   = 3'd5
  } phase_e;

  typedef struct packed {
    logic              last;
    logic              done;
    logic [DelayW-1:0] delay_ms;
    logic [ByteW-1:0]  byte_value;
    kind_e             kind;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/lcd_init_command_list_player_top.sv
// Top level: display initialisation table player with a small result queue.
//
// Usage:
//   s_axis: one table byte per request; tdata = list_byte, tuser = list_start
//   (set on the command count that opens a new list).
//   m_axis: result requests; tdata = {pad, delay_ms, byte_value, kind},
//   tuser = list_done, tlast = last result caused by the input byte.
//   cfg: write of long_delay_ms, always ready, used for delay code 255.
// Results are registered: each is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle while s_axis_tready is high; a byte gives
// zero, one or two results and the output side drains one result per cycle.
// A four-entry result queue sits between the sides; s_axis_tready is high
// while at least two entries are free.
// Reset: queue empty, block waits for a command count, long delay is 500.
// Stall: when m_axis_tready is low the head result holds and input stops
// once the queue can no longer take two results.
`default_nettype none
module lcd_init_command_list_player_top
  import lcd_init_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // [7:0] list_byte
  input  wire logic                s_axis_tuser,   // [0] list_start
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [1:0] kind, [9:2] byte_value,
                                                   // [25:10] delay_ms, rest zero
  output logic                     m_axis_tuser,   // [0] list_done
  output logic                     m_axis_tlast,   // last_of_run
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [DelayW-1:0]   cfg_data_i
);

  localparam int unsigned Depth = 2 ** QueueAw;

  logic [DelayW-1:0]  long_delay_q;
  phase_e             phase_q, phase_d;
  logic [CmdCntW-1:0] cmds_q, cmds_d;
  logic [ArgCntW-1:0] args_q, args_d;
  logic               dly_q, dly_d;

  result_t            queue_q [Depth];
  logic [QueueAw-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;

  result_t            r0, r1;
  logic [1:0]         n_res;
  logic               s_fire, m_fire;
  phase_e             ph;
  logic [CmdCntW-1:0] cmds_dec;
  logic [ArgCntW-1:0] args_dec;
  logic               rel_dly;
  logic [DelayW-1:0]  ms;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (cnt_q <= QueueCntW'(Depth - 2));
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_fire        = m_axis_tvalid & m_axis_tready;

  always_comb begin
    ph       = s_axis_tuser ? PH_COUNT : phase_q;
    phase_d  = phase_q;
    cmds_d   = cmds_q;
    args_d   = args_q;
    dly_d    = dly_q;
    r0       = '0;
    r1       = '0;
    n_res    = 2'd0;
    cmds_dec = cmds_q - CmdCntW'(1);
    args_dec = args_q - ArgCntW'(1);
    rel_dly  = dly_q;
    ms       = (s_axis_tdata == LongCode) ? long_delay_q : DelayW'(s_axis_tdata);
    case (ph)
      PH_COUNT: begin
        cmds_d  = s_axis_tdata;
        args_d  = '0;
        dly_d   = 1'b0;
        phase_d = (s_axis_tdata == '0) ? PH_IDLE : PH_OPCODE;
      end
      PH_OPCODE: begin
        r0.kind       = KIND_CMD;
        r0.byte_value = s_axis_tdata;
        n_res         = 2'd1;
        phase_d       = PH_ARGC;
      end
      PH_ARGC: begin
        args_d  = s_axis_tdata[ArgCntW-1:0];
        dly_d   = s_axis_tdata[ByteW-1];
        rel_dly = s_axis_tdata[ByteW-1];
        if (s_axis_tdata[ArgCntW-1:0] != '0) begin
          phase_d = PH_ARG;
        end else begin
          r0.kind = KIND_RELEASE;
          n_res   = 2'd1;
          if (rel_dly) begin
            phase_d = PH_DELAY;
          end else begin
            cmds_d  = cmds_dec;
            r0.done = (cmds_dec == '0);
            phase_d = (cmds_dec == '0) ? PH_IDLE : PH_OPCODE;
          end
        end
      end
      PH_ARG: begin
        r0.kind       = KIND_DATA;
        r0.byte_value = s_axis_tdata;
        n_res         = 2'd1;
        args_d        = args_dec;
        if (args_dec == '0) begin
          r1.kind = KIND_RELEASE;
          n_res   = 2'd2;
          if (rel_dly) begin
            phase_d = PH_DELAY;
          end else begin
            cmds_d  = cmds_dec;
            r1.done = (cmds_dec == '0);
            phase_d = (cmds_dec == '0) ? PH_IDLE : PH_OPCODE;
          end
        end
      end
      PH_DELAY: begin
        r0.kind     = KIND_DELAY;
        r0.delay_ms = ms;
        n_res       = 2'd1;
        cmds_d      = cmds_dec;
        r0.done     = (cmds_dec == '0);
        phase_d     = (cmds_dec == '0) ? PH_IDLE : PH_OPCODE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_delay_q <= LongDelayRst;
      phase_q      <= PH_COUNT;
      cmds_q       <= '0;
      args_q       <= '0;
      dly_q        <= 1'b0;
      wr_q         <= '0;
      rd_q         <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        long_delay_q <= cfg_data_i;
      end
      if (s_fire) begin
        phase_q <= phase_d;
        cmds_q  <= cmds_d;
        args_q  <= args_d;
        dly_q   <= dly_d;
        wr_q    <= wr_q + QueueAw'(n_res);
      end
      if (m_fire) begin
        rd_q <= rd_q + QueueAw'(1);
      end
      cnt_q <= cnt_q + (s_fire ? QueueCntW'(n_res) : '0) - QueueCntW'(m_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && n_res != 2'd0) begin
      queue_q[wr_q] <= r0;
    end
    if (s_fire && n_res == 2'd2) begin
      queue_q[wr_q + QueueAw'(1)] <= r1;
    end
  end

  assign m_axis_tdata = {{(OutDataW - DelayW - ByteW - KindW){1'b0}},
                         queue_q[rd_q].delay_ms, queue_q[rd_q].byte_value,
                         queue_q[rd_q].kind};
  assign m_axis_tuser = queue_q[rd_q].done;
  assign m_axis_tlast = queue_q[rd_q].last;

endmodule
`default_nettype wire

// File: rtl/lcd_init_checker.sv
// Checker: port-level assertions for the table player, bound to the top.
`default_nettype none
module lcd_init_checker
  import lcd_init_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tuser,
  input wire logic                m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("list completion not on last result of its byte");

  a_data_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == KIND_DATA |-> !m_axis_tuser)
    else $error("data byte flagged as list completion");

  a_release_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == KIND_RELEASE |->
      m_axis_tdata[25:2] == '0 && m_axis_tlast)
    else $error("release marker carries payload or is not last");

  a_cmd_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == KIND_CMD |->
      m_axis_tlast && m_axis_tdata[25:10] == '0)
    else $error("command byte malformed");

endmodule

bind lcd_init_command_list_player_top lcd_init_checker u_lcd_init_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: verif/lcd_init_result_monitor.sv
// Result monitor: predicts the init table player's output requests and checks them.
module lcd_init_result_monitor
  import lcd_init_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  input  wire logic                s_tready_i,
  input  wire logic [ByteW-1:0]    s_tdata_i,   // [7:0] list_byte
  input  wire logic                s_tuser_i,   // [0] list_start
  input  wire logic                m_tvalid_i,
  input  wire logic                m_tready_i,
  input  wire logic [OutDataW-1:0] m_tdata_i,   // [1:0] kind, [9:2] byte_value,
                                                // [25:10] delay_ms, rest zero
  input  wire logic                m_tuser_i,   // [0] list_done
  input  wire logic                m_tlast_i,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [DelayW-1:0]   cfg_data_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_e              table_phase;
  logic [CmdCntW-1:0]  cmds_left;
  logic [ArgCntW-1:0]  args_left;
  logic                delay_flag;
  logic [DelayW-1:0]   long_delay;

  result_t             step_res [2];
  int                  step_n;
  result_t             want_q [$];
  int                  errors;
  int                  n_results;

  task automatic emit(input kind_e k, input logic [ByteW-1:0] b,
                      input logic [DelayW-1:0] ms, input logic done);
    step_res[step_n].kind       = k;
    step_res[step_n].byte_value = b;
    step_res[step_n].delay_ms   = ms;
    step_res[step_n].done       = done;
    step_res[step_n].last       = 1'b0;
    step_n++;
  endtask

  task automatic close_command(output logic done);
    cmds_left = cmds_left - 1'b1;
    if (cmds_left == '0) begin
      table_phase = PH_IDLE;
      done = 1'b1;
    end else begin
      table_phase = PH_OPCODE;
      done = 1'b0;
    end
  endtask

  task automatic release_cs();
    logic done;
    done = 1'b0;
    if (delay_flag) begin
      table_phase = PH_DELAY;
    end else begin
      close_command(done);
    end
    emit(KIND_RELEASE, '0, '0, done);
  endtask

  task automatic predict_byte(input logic [ByteW-1:0] b, input logic start);
    logic              done;
    logic [DelayW-1:0] ms;
    step_n = 0;
    if (start) table_phase = PH_COUNT;
    case (table_phase)
      PH_COUNT: begin
        cmds_left   = b;
        args_left   = '0;
        delay_flag  = 1'b0;
        table_phase = (b == '0) ? PH_IDLE : PH_OPCODE;
      end
      PH_OPCODE: begin
        emit(KIND_CMD, b, '0, 1'b0);
        table_phase = PH_ARGC;
      end
      PH_ARGC: begin
        args_left  = b[ArgCntW-1:0];
        delay_flag = b[ByteW-1];
        if (args_left != '0) begin
          table_phase = PH_ARG;
        end else begin
          release_cs();
        end
      end
      PH_ARG: begin
        emit(KIND_DATA, b, '0, 1'b0);
        args_left = args_left - 1'b1;
        if (args_left == '0) release_cs();
      end
      PH_DELAY: begin
        ms = (b == LongCode) ? long_delay : {8'd0, b};
        close_command(done);
        emit(KIND_DELAY, '0, ms, done);
      end
      default: begin
        table_phase = PH_IDLE;
      end
    endcase
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) want_q.push_back(step_res[i]);
  endtask

  task automatic report(input string field, input logic [DelayW-1:0] want,
                        input logic [DelayW-1:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      table_phase = PH_COUNT;
      cmds_left   = '0;
      args_left   = '0;
      delay_flag  = 1'b0;
      long_delay  = LongDelayRst;
      want_q.delete();
      errors      = 0;
      n_results   = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        n_results++;
        if (want_q.size() == 0) begin
          $display("%0t: result request with nothing expected, tdata %h tuser %b tlast %b",
                   $time, m_tdata_i, m_tuser_i, m_tlast_i);
          errors++;
        end else begin
          want = want_q.pop_front();
          if (m_tdata_i[1:0] != want.kind)
            report("kind", 16'(want.kind), 16'(m_tdata_i[1:0]));
          if (m_tdata_i[9:2] != want.byte_value)
            report("byte_value", 16'(want.byte_value), 16'(m_tdata_i[9:2]));
          if (m_tdata_i[25:10] != want.delay_ms)
            report("delay_ms", want.delay_ms, m_tdata_i[25:10]);
          if (m_tdata_i[31:26] != '0)
            report("tdata padding", '0, 16'(m_tdata_i[31:26]));
          if (m_tuser_i != want.done)
            report("list_done", 16'(want.done), 16'(m_tuser_i));
          if (m_tlast_i != want.last)
            report("last_of_run", 16'(want.last), 16'(m_tlast_i));
        end
      end
      // a byte taken in the same cycle as a register write still sees the old value
      if (s_tvalid_i && s_tready_i) predict_byte(s_tdata_i, s_tuser_i);
      if (cfg_valid_i && cfg_ready_i) long_delay = cfg_data_i;
    end
    errors_o  <= errors;
    pending_o <= want_q.size();
    results_o <= n_results;
  end

endmodule

// File: verif/testbench.sv
// Testbench top: drives table bytes, delay-register writes and result back-pressure.
module testbench
  import lcd_init_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles    = 120;
  localparam int SettleCycles  = 4;
  localparam int PhaseItems    = 135;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [DelayW-1:0]   cfg_data_i    = '0;

  int errors, pending, results;
  int bytes_sent  = 0;
  int cfg_writes  = 0;
  int tx_idle_pct = 21;
  int rx_idle_pct = 57;
  int hold_req    = 0;
  int hold_ack    = 0;
  int hold_left   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lcd_init_command_list_player_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  lcd_init_result_monitor u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tlast_i   (m_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  // receiver: random back-pressure, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic start);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // stop offering and wait for every expected result, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_long_delay(input logic [DelayW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  // one well-formed list with random content, sometimes cut short or followed by noise
  task automatic play_random_list();
    logic [8:0]       seq [$];
    logic [ByteW-1:0] argc;
    int               n_cmds, n_args, cut;
    n_cmds = ($urandom_range(15) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    seq.push_back({1'b1, 8'(n_cmds)});
    for (int c = 0; c < n_cmds; c++) begin
      seq.push_back({1'b0, 8'($urandom_range(255))});
      n_args = ($urandom_range(59) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 4);
      argc   = {1'($urandom_range(1)), 7'(n_args)};
      seq.push_back({1'b0, argc});
      repeat (n_args) seq.push_back({1'b0, 8'($urandom_range(255))});
      if (argc[7])
        seq.push_back({1'b0, ($urandom_range(3) == 0) ? LongCode : 8'($urandom_range(255))});
    end
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, seq.size() - 1);
      seq = seq[0:cut-1];
    end
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 4))
        seq.push_back({1'($urandom_range(7) == 0), 8'($urandom_range(255))});
    foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
  endtask

  initial begin : stimulus
    logic [8:0]        directed [$];
    logic [DelayW-1:0] settings [3];
    int                phase_base;
    bit                held, paused;

    // opcode, argc with and without delay, long code, zero delay, stray bytes,
    // empty list, restart mid-list
    directed = '{
      {1'b1, 8'd3},
      {1'b0, 8'h00}, {1'b0, 8'h00},
      {1'b0, 8'hFF}, {1'b0, 8'h82}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'hFF},
      {1'b0, 8'h5A}, {1'b0, 8'h80}, {1'b0, 8'h00},
      {1'b0, 8'h12},
      {1'b1, 8'h00},
      {1'b0, 8'h34},
      {1'b1, 8'hFF}, {1'b0, 8'h01},
      {1'b1, 8'd2}, {1'b0, 8'h11}, {1'b0, 8'h01}, {1'b0, 8'hAA},
      {1'b1, 8'd1}, {1'b0, 8'h22}, {1'b0, 8'h81}, {1'b0, 8'h55}, {1'b0, 8'hFE}
    };
    settings = '{16'hFFFF, 16'h0000, 16'($urandom_range(65535))};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct <= 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct <= 21;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      write_long_delay(settings[mode]);
      phase_base = bytes_sent;
      held   = 1'b0;
      paused = 1'b0;
      while (bytes_sent - phase_base < PhaseItems) begin
        if (!held && bytes_sent - phase_base >= 30) begin
          hold_req <= hold_req + 1;
          held = 1'b1;
        end
        if (!paused && bytes_sent - phase_base >= 70) begin
          drain();
          paused = 1'b1;
        end
        play_random_list();
      end
      drain();
    end

    $display("Covered %0d table bytes and %0d result requests under three idling mixes,",
             bytes_sent, results);
    $display("with %0d long-delay register settings besides the reset value.", cfg_writes);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
